/* design/efr_pkg.sv */
// ----------------------------------------------------------------------------
// efr_pkg
// Shared types and codes for the escaped frame receiver: result kinds,
// verdict codes, header masks and the record passed from front to back.
// ----------------------------------------------------------------------------
package efr_pkg;

	localparam int BYTE_W    = 8;
	localparam int CRC_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_TYP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TYP  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POLY     = 2'd3;

	localparam logic [BYTE_W-1:0] RST_ESCAPE   = 8'd27;
	localparam logic [BYTE_W-1:0] RST_DATA_TYP = 8'd8;
	localparam logic [BYTE_W-1:0] RST_ACK_TYP  = 8'd16;
	localparam logic [CRC_W-1:0]  RST_POLY     = 16'h1021;

	localparam logic [BYTE_W-1:0] TYPE_MASK  = 8'hf8;
	localparam logic [BYTE_W-1:0] TRIAL_MASK = 8'h07;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// verdict codes
	localparam logic [2:0] V_DATA_OK  = 3'd0;
	localparam logic [2:0] V_ACK_OK   = 3'd1;
	localparam logic [2:0] V_UNKNOWN  = 3'd2;
	localparam logic [2:0] V_BAD_CRC  = 3'd3;
	localparam logic [2:0] V_BAD_END  = 3'd4;

	// one queued result, before field formatting
	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] data;
		logic [2:0]        verdict;
		logic [BYTE_W-1:0] type_byte;
		logic [BYTE_W-1:0] id;
		logic [BYTE_W-1:0] port;
		logic [BYTE_W-1:0] len;
	} efr_rec_t;

endpackage

/* design/efr_if.sv */
// ----------------------------------------------------------------------------
// efr_if
// Valid/ready channels: received byte stream and formatted result stream.
// ----------------------------------------------------------------------------
interface efr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efr_result_if;
	logic       valid;
	logic       ready;
	logic       out_kind;
	logic [7:0] payload_byte;
	logic [2:0] verdict;
	logic [7:0] message_id;
	logic [7:0] port_number;
	logic [7:0] payload_length;
	logic [2:0] trial_count;

	modport source (output valid, output out_kind, output payload_byte, output verdict,
		output message_id, output port_number, output payload_length,
		output trial_count, input ready);
	modport sink (input valid, input out_kind, input payload_byte, input verdict,
		input message_id, input port_number, input payload_length,
		input trial_count, output ready);
endinterface

/* design/efr_front.sv */
// ----------------------------------------------------------------------------
// efr_front
// Frame parser: hunts the start pair, stores the header, runs the CRC-16 and
// pushes payload and verdict records into the result queue.
// ----------------------------------------------------------------------------
module efr_front import efr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 byte_valid,
	input  logic [BYTE_W-1:0]    byte_data,
	output logic                 byte_ready,
	input  logic                 queue_full,
	output logic                 push,
	output efr_rec_t             push_rec
);

	localparam logic [2:0] PH_HUNT1  = 3'd0;
	localparam logic [2:0] PH_HUNT2  = 3'd1;
	localparam logic [2:0] PH_HEADER = 3'd2;
	localparam logic [2:0] PH_BODY   = 3'd3;
	localparam logic [2:0] PH_END1   = 3'd4;
	localparam logic [2:0] PH_END2   = 3'd5;

	localparam logic [8:0] HDR_BYTES = 9'd4;

	logic [BYTE_W-1:0] escape_q;
	logic [BYTE_W-1:0] data_typ_q;
	logic [BYTE_W-1:0] ack_typ_q;
	logic [CRC_W-1:0]  poly_q;

	logic [2:0]        ph_q, ph_d;
	logic [8:0]        cnt_q, cnt_d;
	logic [CRC_W-1:0]  crc_q, crc_d;
	logic [BYTE_W-1:0] hdr_q [4];

	logic              accept;
	logic              want_push;
	logic [CRC_W-1:0]  crc_next;
	logic [8:0]        cnt_inc;
	logic [8:0]        body_end;
	logic [BYTE_W-1:0] esc_plus1;
	logic [BYTE_W-1:0] esc_plus2;
	logic [BYTE_W-1:0] type_hi;
	logic [2:0]        verdict_d;
	logic              kind_d;

	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] rem,
		input logic [BYTE_W-1:0] b, input logic [CRC_W-1:0] poly);
		logic [CRC_W-1:0] r;
		r = rem ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (r[CRC_W-1]) begin
				r = {r[CRC_W-2:0], 1'b0} ^ poly;
			end else begin
				r = {r[CRC_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	assign byte_ready = !queue_full;
	assign accept     = byte_valid && byte_ready;

	assign crc_next  = crc_feed(crc_q, byte_data, poly_q);
	assign cnt_inc   = cnt_q + 9'd1;
	assign body_end  = {1'b0, hdr_q[3]} + 9'd2;
	assign esc_plus1 = escape_q + 8'd1;
	assign esc_plus2 = escape_q + 8'd2;
	assign type_hi   = hdr_q[0] & TYPE_MASK;

	always_comb begin
		ph_d      = ph_q;
		cnt_d     = cnt_q;
		crc_d     = crc_q;
		want_push = 1'b0;
		kind_d    = KIND_PAYLOAD;
		verdict_d = V_DATA_OK;
		case (ph_q)
			PH_HUNT2: begin
				if (byte_data == esc_plus1) begin
					ph_d  = PH_HEADER;
					cnt_d = '0;
					crc_d = '0;
				end else begin
					ph_d = PH_HUNT1;
				end
			end
			PH_HEADER: begin
				crc_d = crc_next;
				if (cnt_inc >= HDR_BYTES) begin
					cnt_d = '0;
					ph_d  = PH_BODY;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			PH_BODY: begin
				crc_d = crc_next;
				if (cnt_q < {1'b0, hdr_q[3]}) begin
					want_push = 1'b1;
				end
				if (cnt_inc >= body_end) begin
					cnt_d = '0;
					ph_d  = PH_END1;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			PH_END1: begin
				if (byte_data == escape_q) begin
					ph_d = PH_END2;
				end else begin
					want_push = 1'b1;
					kind_d    = KIND_VERDICT;
					verdict_d = V_BAD_END;
					ph_d      = PH_HUNT1;
				end
			end
			PH_END2: begin
				want_push = 1'b1;
				kind_d    = KIND_VERDICT;
				ph_d      = PH_HUNT1;
				if (byte_data != esc_plus2) begin
					verdict_d = V_BAD_END;
				end else if (crc_q != '0) begin
					verdict_d = V_BAD_CRC;
				end else if (type_hi == data_typ_q) begin
					verdict_d = V_DATA_OK;
				end else if (type_hi == ack_typ_q) begin
					verdict_d = V_ACK_OK;
				end else begin
					verdict_d = V_UNKNOWN;
				end
			end
			default: begin
				ph_d = (byte_data == escape_q) ? PH_HUNT2 : PH_HUNT1;
			end
		endcase
	end

	assign push               = accept && want_push;
	assign push_rec.kind      = kind_d;
	assign push_rec.data      = byte_data;
	assign push_rec.verdict   = verdict_d;
	assign push_rec.type_byte = hdr_q[0];
	assign push_rec.id        = hdr_q[1];
	assign push_rec.port      = hdr_q[2];
	assign push_rec.len       = hdr_q[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q   <= RST_ESCAPE;
			data_typ_q <= RST_DATA_TYP;
			ack_typ_q  <= RST_ACK_TYP;
			poly_q     <= RST_POLY;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ESCAPE:   escape_q   <= cfg_data[BYTE_W-1:0];
				CFG_DATA_TYP: data_typ_q <= cfg_data[BYTE_W-1:0];
				CFG_ACK_TYP:  ack_typ_q  <= cfg_data[BYTE_W-1:0];
				CFG_POLY:     poly_q     <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_HUNT1;
			cnt_q <= '0;
			crc_q <= '0;
		end else if (accept) begin
			ph_q  <= ph_d;
			cnt_q <= cnt_d;
			crc_q <= crc_d;
		end
	end

	// header bytes land by position; no reset needed
	always_ff @(posedge clk) begin
		if (accept && ph_q == PH_HEADER) begin
			hdr_q[cnt_q[1:0]] <= byte_data;
		end
	end

endmodule

/* design/efr_fifo.sv */
// ----------------------------------------------------------------------------
// efr_fifo
// Two-entry queue of result records between the parser and the output stage.
// ----------------------------------------------------------------------------
module efr_fifo import efr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  efr_rec_t push_rec,
	output logic     full,
	input  logic     pop,
	output logic     head_valid,
	output efr_rec_t head_rec
);

	efr_rec_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_rec   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/efr_back.sv */
// ----------------------------------------------------------------------------
// efr_back
// Output stage: formats a queued record into result fields and holds it in
// a register until the downstream side takes the transaction.
// ----------------------------------------------------------------------------
module efr_back import efr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  efr_rec_t           head_rec,
	output logic               pop,
	efr_result_if.source       res
);

	logic        valid_q;
	logic        load;
	logic        kind_q;
	logic [7:0]  pbyte_q;
	logic [2:0]  verdict_q;
	logic [7:0]  id_q;
	logic [7:0]  port_q;
	logic [7:0]  len_q;
	logic [2:0]  trial_q;
	logic [7:0]  trial_full;

	assign load       = !valid_q || res.ready;
	assign pop        = head_valid && load;
	assign trial_full = head_rec.type_byte & TRIAL_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= head_valid;
		end
	end

	// payload byte and verdict are zero in the other kind of result
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q    <= head_rec.kind;
			pbyte_q   <= (head_rec.kind == KIND_PAYLOAD) ? head_rec.data : 8'h00;
			verdict_q <= (head_rec.kind == KIND_VERDICT) ? head_rec.verdict : V_DATA_OK;
			id_q      <= head_rec.id;
			port_q    <= head_rec.port;
			len_q     <= head_rec.len;
			trial_q   <= trial_full[2:0];
		end
	end

	assign res.valid          = valid_q;
	assign res.out_kind       = kind_q;
	assign res.payload_byte   = pbyte_q;
	assign res.verdict        = verdict_q;
	assign res.message_id     = id_q;
	assign res.port_number    = port_q;
	assign res.payload_length = len_q;
	assign res.trial_count    = trial_q;

endmodule

/* design/escaped_frame_receiver_crc16.sv */
// ----------------------------------------------------------------------------
// escaped_frame_receiver_crc16
// Escaped frame receiver with CRC-16 check: parser front end, result queue
// and registered output stage.
//
//   channel  | direction | payload
//   ---------+-----------+--------------------------------------------------
//   rx_ch    | in        | rx_byte
//   res_ch   | out       | out_kind, payload_byte, verdict, message_id,
//            |           | port_number, payload_length, trial_count
//   cfg      | in        | cfg_we, cfg_index, cfg_data (write only)
//
// One byte per cycle while the queue is not full: the parser does its phase
// step and the full 8-bit CRC update in the cycle the byte is taken. A
// result reaches res_ch through the queue write and then the output register.
// rx_ch.ready drops only when the two-entry queue is full, i.e. when res_ch
// has stalled long enough. arst_n clears phase, counters, CRC, queue and
// output valid and loads the register reset values.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_crc16 import efr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	efr_byte_if.sink             rx_ch,
	efr_result_if.source         res_ch
);

	logic     push;
	efr_rec_t push_rec;
	logic     full;
	logic     pop;
	logic     head_valid;
	efr_rec_t head_rec;

	efr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.byte_valid (rx_ch.valid),
		.byte_data  (rx_ch.rx_byte),
		.byte_ready (rx_ch.ready),
		.queue_full (full),
		.push       (push),
		.push_rec   (push_rec)
	);

	efr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_rec   (head_rec)
	);

	efr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop),
		.res        (res_ch)
	);

endmodule
